// File: rtl/core/tli_pkg.sv
// Shared constants and types for the table linear interpolator.
package tli_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int N_W         = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_W     = 6;
   localparam int COUNT_MIN   = 2;
   localparam int COUNT_RST   = 2;
   localparam int CMP_W       = (N_W > COUNT_W) ? N_W : COUNT_W;
   localparam int IDX_W       = 5;
   localparam int IDX_EXT_W   = (IDX_W > ADDR_W) ? IDX_W + 1 : ADDR_W + 1;
   localparam int DATA_W      = 16;
   localparam int ENTRY_W     = 2 * DATA_W;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = $clog2(FRAC_W);
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int SUM_W       = PROD_W - FRAC_W;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage

// File: rtl/core/tli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/table_linear_interpolator.sv
// Top level of the breakpoint-table linear interpolator.
//
// A beat is taken on start while busy is low. A load beat (mode 0) writes one
// (x, y) breakpoint into the table in that same edge, raises no busy and gives
// no result. A query beat (mode 1) raises busy and walks the first n entries,
// n being entry_count clamped to [2, 32], one table read per cycle from the
// single-read-port RAM; the first stored x equal to the query ends the walk
// early with exact_hit. Otherwise, after the walk, a query outside
// [x[0], x[n-1]] returns out_of_range with zero, and a bracketed query runs
// a 16-step restoring divider for the fraction, one multiply and one add.
// The result is shown on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it, so it must take it then. busy is
// already low in that cycle, so the next beat may be taken at the same edge
// as the result. entry_count may only be written while busy is low. The
// table holds no reset value: an entry read before it was written gives an
// undefined answer.
module table_linear_interpolator
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request beat
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [DATA_W-1:0]  req_entry_x,
   input  logic signed [DATA_W-1:0]  req_entry_y,
   input  logic signed [DATA_W-1:0]  req_query_x,
   // result beat
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_value_y,
   output logic                      rsp_out_of_range,
   output logic                      rsp_exact_hit,
   // configuration
   input  logic                      csr_write_enable,
   input  logic [COUNT_W-1:0]        csr_write_data
);

   // --- state -------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]  q_ff, q_in;
   logic [N_W-1:0]            n_ff, n_in;
   logic [N_W-1:0]            issue_ff, issue_in;
   logic [N_W-1:0]            proc_ff, proc_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic signed [DATA_W-1:0]  prev_x_ff, prev_x_in;
   logic signed [DATA_W-1:0]  prev_y_ff, prev_y_in;
   logic signed [DATA_W-1:0]  x0_ff, x0_in;
   logic                      pair_ff, pair_in;
   // divider / multiplier operands
   logic [DATA_W-1:0]         den_ff, den_in;
   logic signed [DATA_W-1:0]  ya_ff, ya_in;
   logic signed [DIFF_W-1:0]  dy_ff, dy_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [FRAC_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   // result beat
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                      rsp_oor_ff, rsp_oor_in;
   logic                      rsp_hit_ff, rsp_hit_in;

   // --- table RAM: {x, y} per entry -------------------------------------------
   logic                      accept;
   logic [IDX_EXT_W-1:0]      load_idx_ext;
   logic                      wr_en;
   logic                      rd_en;
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [DATA_W-1:0]  cur_x;
   logic signed [DATA_W-1:0]  cur_y;

   assign accept       = start && (state_ff == ST_IDLE);
   assign load_idx_ext = IDX_EXT_W'(req_entry_index);
   // slots beyond the table are dropped
   assign wr_en        = accept && (req_mode == MODE_LOAD)
                         && (load_idx_ext < IDX_EXT_W'(TABLE_DEPTH));
   assign rd_en        = (state_ff == ST_SCAN) && (issue_ff < n_ff);
   assign cur_x        = rd_data[ENTRY_W-1:DATA_W];
   assign cur_y        = rd_data[DATA_W-1:0];

   tli_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_idx_ext[ADDR_W-1:0]),
      .wr_data ({req_entry_x, req_entry_y}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // --- count clamp: below 2 acts as 2, above depth as depth -----------------
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cnt_clamp;

   assign cnt_ext   = CMP_W'(cnt_ff);
   assign cnt_clamp = (cnt_ext < CMP_W'(COUNT_MIN))   ? CMP_W'(COUNT_MIN)   :
                      (cnt_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) :
                      cnt_ext;

   // --- datapath helpers ------------------------------------------------------
   logic                      proc_last;
   logic signed [DIFF_W-1:0]  num_diff;
   logic signed [DIFF_W-1:0]  den_diff;
   logic signed [DIFF_W-1:0]  dy_diff;
   logic [DATA_W:0]           rem_sh;
   logic                      rem_ge;
   logic [DATA_W:0]           rem_sub;
   logic signed [SUM_W-1:0]   fin_sum;

   assign proc_last = (N_W'(proc_ff + N_W'(1)) == n_ff);
   assign num_diff  = $signed({q_ff[DATA_W-1], q_ff})
                      - $signed({prev_x_ff[DATA_W-1], prev_x_ff});
   assign den_diff  = $signed({cur_x[DATA_W-1], cur_x})
                      - $signed({prev_x_ff[DATA_W-1], prev_x_ff});
   assign dy_diff   = $signed({cur_y[DATA_W-1], cur_y})
                      - $signed({prev_y_ff[DATA_W-1], prev_y_ff});

   // one restoring step: remainder stays below the divisor
   assign rem_sh    = {rem_ff, 1'b0};
   assign rem_ge    = rem_sh >= {1'b0, den_ff};
   assign rem_sub   = rem_sh - {1'b0, den_ff};

   // arithmetic shift of the product floors it
   assign fin_sum   = $signed({{(SUM_W-DATA_W){ya_ff[DATA_W-1]}}, ya_ff})
                      + $signed(prod_ff[PROD_W-1:FRAC_W]);

   // --- sequencer -------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      n_in         = n_ff;
      issue_in     = issue_ff;
      proc_in      = proc_ff;
      rd_vld_in    = rd_en;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      x0_in        = x0_ff;
      pair_in      = pair_ff;
      den_in       = den_ff;
      ya_in        = ya_ff;
      dy_in        = dy_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_hit_in   = rsp_hit_ff;

      if (csr_write_enable) begin
         cnt_in = csr_write_data;
      end

      if (rd_en) begin
         issue_in = N_W'(issue_ff + N_W'(1));
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_QUERY)) begin
               q_in      = req_query_x;
               n_in      = N_W'(cnt_clamp);
               issue_in  = '0;
               proc_in   = '0;
               rd_vld_in = 1'b0;
               pair_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               if (cur_x == q_ff) begin
                  // first exact match wins
                  rsp_valid_in = 1'b1;
                  rsp_value_in = cur_y;
                  rsp_oor_in   = 1'b0;
                  rsp_hit_in   = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  if (proc_ff == '0) begin
                     x0_in = cur_x;
                  end else if (!pair_ff && (prev_x_ff < q_ff) && (q_ff < cur_x)) begin
                     pair_in = 1'b1;
                     rem_in  = num_diff[DATA_W-1:0];
                     den_in  = den_diff[DATA_W-1:0];
                     ya_in   = prev_y_ff;
                     dy_in   = dy_diff;
                  end
                  prev_x_in = cur_x;
                  prev_y_in = cur_y;
                  proc_in   = N_W'(proc_ff + N_W'(1));
                  if (proc_last) begin
                     if ((q_ff < x0_ff) || (q_ff > cur_x)) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_oor_in   = 1'b1;
                        rsp_hit_in   = 1'b0;
                        state_in     = ST_IDLE;
                     end else begin
                        quo_in   = '0;
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_in  = {quo_ff[FRAC_W-2:0], rem_ge};
            step_in = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, quo_ff}) * dy_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = fin_sum[DATA_W-1:0];
            rsp_oor_in   = 1'b0;
            rsp_hit_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= COUNT_W'(COUNT_RST);
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      n_ff         <= n_in;
      issue_ff     <= issue_in;
      proc_ff      <= proc_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      x0_ff        <= x0_in;
      pair_ff      <= pair_in;
      den_ff       <= den_in;
      ya_ff        <= ya_in;
      dy_ff        <= dy_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_y      = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_exact_hit    = rsp_hit_ff;

endmodule

// File: verif/tli_checker.sv
// Checker for the interpolator: mirrors the breakpoint table, predicts each query and compares.
`timescale 1ns / 100ps

module tli_checker
   import tli_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [DATA_W-1:0]  req_entry_x,
   input  logic signed [DATA_W-1:0]  req_entry_y,
   input  logic signed [DATA_W-1:0]  req_query_x,
   input  logic                      rsp_valid,
   input  logic signed [DATA_W-1:0]  rsp_value_y,
   input  logic                      rsp_out_of_range,
   input  logic                      rsp_exact_hit,
   input  logic                      csr_write_enable,
   input  logic [COUNT_W-1:0]        csr_write_data,
   output int                        mismatch_count,
   output int                        answers_outstanding
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value_y;
      logic                     out_of_range;
      logic                     exact_hit;
   } answer_type;

   logic signed [DATA_W-1:0] x_tab [TABLE_DEPTH];
   logic signed [DATA_W-1:0] y_tab [TABLE_DEPTH];
   logic [COUNT_W-1:0]       entry_count_q;
   answer_type               answers_due [$];

   initial begin
      mismatch_count      = 0;
      answers_outstanding = 0;
      entry_count_q       = COUNT_W'(COUNT_RST);
   end

   // first exact match wins, then the span test, then the first bracketing pair
   function automatic answer_type interpolate_at(logic signed [DATA_W-1:0] q);
      answer_type ans;
      int      n;
      longint  a, c, ya, yc, fraction, product, sum;
      ans.value_y      = '0;
      ans.out_of_range = 1'b0;
      ans.exact_hit    = 1'b0;
      n = int'(entry_count_q);
      if (n < COUNT_MIN) n = COUNT_MIN;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      for (int i = 0; i < n; i++) begin
         if (x_tab[i] == q) begin
            ans.value_y   = y_tab[i];
            ans.exact_hit = 1'b1;
            return ans;
         end
      end
      if (q < x_tab[0] || q > x_tab[n-1]) begin
         ans.out_of_range = 1'b1;
         return ans;
      end
      for (int i = 0; i + 1 < n; i++) begin
         a = longint'(x_tab[i]);
         c = longint'(x_tab[i+1]);
         if (a < longint'(q) && longint'(q) < c) begin
            ya       = longint'(y_tab[i]);
            yc       = longint'(y_tab[i+1]);
            fraction = ((longint'(q) - a) <<< FRAC_W) / (c - a);
            product  = fraction * (yc - ya);
            sum      = ya + (product >>> FRAC_W);
            ans.value_y = sum[DATA_W-1:0];
            break;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         entry_count_q = COUNT_W'(COUNT_RST);
         answers_due.delete();
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("result beat with no query waiting: value_y %0d", rsp_value_y);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_value_y !== want.value_y) begin
                  $error("value_y: expected %0d, got %0d", want.value_y, rsp_value_y);
                  mismatch_count++;
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0b, got %0b",
                         want.out_of_range, rsp_out_of_range);
                  mismatch_count++;
               end
               if (rsp_exact_hit !== want.exact_hit) begin
                  $error("exact_hit: expected %0b, got %0b", want.exact_hit, rsp_exact_hit);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_mode == MODE_LOAD) begin
               x_tab[req_entry_index] = req_entry_x;
               y_tab[req_entry_index] = req_entry_y;
            end else begin
               answers_due = {answers_due, interpolate_at(req_query_x)};
            end
         end
         if (csr_write_enable) entry_count_q = csr_write_data;
      end
      answers_outstanding = answers_due.size();
   end

endmodule

// File: verif/tb_table_linear_interpolator.sv
// Testbench top for the table linear interpolator: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb_table_linear_interpolator
   import tli_pkg::*;
();

   localparam int ITEM_TARGET   = 1100;
   localparam int SETTLE_CYCLES = 60;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     start            = 1'b0;
   logic                     busy;
   logic                     req_mode         = MODE_LOAD;
   logic [IDX_W-1:0]         req_entry_index  = '0;
   logic signed [DATA_W-1:0] req_entry_x      = '0;
   logic signed [DATA_W-1:0] req_entry_y      = '0;
   logic signed [DATA_W-1:0] req_query_x      = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_value_y;
   logic                     rsp_out_of_range;
   logic                     rsp_exact_hit;
   logic                     csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]       csr_write_data   = '0;

   int mismatch_count;
   int answers_outstanding;

   // stimulus-side copy of the loaded x values, only used to aim queries
   logic signed [DATA_W-1:0] x_loaded [TABLE_DEPTH];
   int                       live_entries = COUNT_RST;
   int                       beats_sent   = 0;
   bit                       no_idle      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   table_linear_interpolator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_entry_x      (req_entry_x),
      .req_entry_y      (req_entry_y),
      .req_query_x      (req_query_x),
      .rsp_valid        (rsp_valid),
      .rsp_value_y      (rsp_value_y),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_exact_hit    (rsp_exact_hit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   tli_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_entry_index     (req_entry_index),
      .req_entry_x         (req_entry_x),
      .req_entry_y         (req_entry_y),
      .req_query_x         (req_query_x),
      .rsp_valid           (rsp_valid),
      .rsp_value_y         (rsp_value_y),
      .rsp_out_of_range    (rsp_out_of_range),
      .rsp_exact_hit       (rsp_exact_hit),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .answers_outstanding (answers_outstanding)
   );

   // uniform integer in [lo_v, hi_v]
   function automatic int pick(int lo_v, int hi_v);
      return lo_v + int'($urandom_range(hi_v - lo_v));
   endfunction

   function automatic int rand_word();
      return pick(-32768, 32767);
   endfunction

   // mostly back-to-back, some short gaps, the odd long one
   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = pick(0, 99);
      if (r < 55) return 0;
      if (r < 85) return pick(1, 3);
      return pick(8, 40);
   endfunction

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Drive one beat at the falling edge and keep start up until an edge
   // sees busy low. busy only moves on rising edges, so its value here
   // is what the next rising edge will see. Returns on a falling edge.
   task automatic send_beat(input logic mode, input int idx, input int ex,
                            input int ey, input int qx);
      logic taken;
      start           <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= idx[IDX_W-1:0];
      req_entry_x     <= ex[DATA_W-1:0];
      req_entry_y     <= ey[DATA_W-1:0];
      req_query_x     <= qx[DATA_W-1:0];
      if (mode == MODE_LOAD) x_loaded[idx] = ex[DATA_W-1:0];
      do begin
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      beats_sent++;
      hold_off(gap_len());
   endtask

   // Drop start and wait for every outstanding answer; the wait loop checks only
   // after a falling edge, so start never falls and rises in the same step.
   task automatic settle(input int extra);
      start <= 1'b0;
      do @(negedge clock); while (answers_outstanding != 0 || busy);
      repeat (extra) @(negedge clock);
   endtask

   // entry_count may only change while the block is idle
   task automatic write_count(input int value);
      settle(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[COUNT_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      live_entries = value;
      if (live_entries < COUNT_MIN) live_entries = COUNT_MIN;
      if (live_entries > TABLE_DEPTH) live_entries = TABLE_DEPTH;
   endtask

   // Strictly ascending table over slots 0..slots-1: wide, medium or dense
   // spacing, with y drawn freely and now and then pinned at full scale.
   task automatic load_ascending(input int slots);
      int r, cap, lo, hi, room, xv, yv;
      r = pick(0, 99);
      if (r < 40) begin
         cap = 65535 / slots * 2;
         lo  = -32768;
      end else if (r < 70) begin
         cap = pick(1, 200);
         lo  = pick(-32768, 0);
      end else begin
         cap = pick(1, 4);
         lo  = pick(-32768, 32767 - 5 * slots);
      end
      for (int i = 0; i < slots; i++) begin
         hi   = 32767 - (slots - 1 - i);
         room = hi - lo;
         if (room > cap) room = cap;
         xv = lo + pick(0, room);
         lo = xv + 1;
         if (pick(0, 3) == 0) yv = pick(0, 1) ? 32767 : -32768;
         else yv = rand_word();
         send_beat(MODE_LOAD, i, xv, yv, rand_word());
      end
   endtask

   // Queries aimed at stored x values, inside a bracket, off either end of
   // the span, or anywhere at all.
   task automatic send_query();
      int r, k, lo, hi, q;
      r = pick(0, 99);
      q = rand_word();
      if (r < 25) begin
         q = x_loaded[pick(0, live_entries - 1)];
      end else if (r < 65) begin
         k  = pick(0, live_entries - 2);
         lo = x_loaded[k];
         hi = x_loaded[k+1];
         if (lo > hi) begin
            lo = x_loaded[k+1];
            hi = x_loaded[k];
         end
         q = pick(lo, hi);
      end else if (r < 80) begin
         lo = x_loaded[0];
         hi = x_loaded[live_entries-1];
         if (r < 72 && lo > -32768) q = pick(-32768, lo - 1);
         else if (hi < 32767) q = pick(hi + 1, 32767);
      end
      send_beat(MODE_QUERY, pick(0, TABLE_DEPTH - 1), rand_word(), rand_word(), q);
   endtask

   initial begin
      int setting, phase, r;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, entry_count at its reset value of two.
      // Full-scale span: exact hits at both ends, interpolation across it.
      send_beat(MODE_LOAD, 0, -32768, -32768, 0);
      send_beat(MODE_LOAD, 1, 32767, 32767, 0);
      send_beat(MODE_QUERY, 0, 0, 0, -32768);
      send_beat(MODE_QUERY, 0, 0, 0, 32767);
      send_beat(MODE_QUERY, 0, 0, 0, 0);
      send_beat(MODE_QUERY, 0, 0, 0, -32767);
      // falling slope, full-scale y step, queries just off either end
      send_beat(MODE_LOAD, 0, 16'sh0100, 32767, 0);
      send_beat(MODE_LOAD, 1, 16'sh0300, -32768, 0);
      send_beat(MODE_QUERY, 0, 0, 0, 16'sh0200);
      send_beat(MODE_QUERY, 0, 0, 0, 16'sh00FF);
      send_beat(MODE_QUERY, 0, 0, 0, 16'sh0301);
      send_beat(MODE_QUERY, 0, 0, 0, 16'sh02FF);
      // x step of two: fraction of exactly one half
      send_beat(MODE_LOAD, 1, 16'sh0102, -32768, 0);
      send_beat(MODE_QUERY, 0, 0, 0, 16'sh0101);
      // duplicate x: the lower slot answers
      send_beat(MODE_LOAD, 0, 5, 16'sh1234, 0);
      send_beat(MODE_LOAD, 1, 5, 16'sh4321, 0);
      send_beat(MODE_QUERY, 0, 0, 0, 5);
      // descending pair: hit on the second slot, miss above the last
      send_beat(MODE_LOAD, 1, 4, -1, 0);
      send_beat(MODE_QUERY, 0, 0, 0, 4);
      send_beat(MODE_QUERY, 0, 0, 0, 6);
      // counts below the minimum behave as two
      write_count(0);
      send_beat(MODE_QUERY, 0, 0, 0, 5);
      write_count(1);
      send_beat(MODE_QUERY, 0, 0, 0, 4);

      // Random phases: new count, fresh ascending table, then a query stream
      // with stray loads and the occasional full drain. The first phase
      // fills every slot so no later count can reach an unwritten entry.
      phase = 0;
      while (beats_sent < ITEM_TARGET) begin
         case (phase)
            0:       setting = 63;
            1:       setting = 2;
            2:       setting = 32;
            3:       setting = 0;
            4:       setting = 1;
            5:       setting = 33;
            default: setting = pick(0, 63);
         endcase
         write_count(setting);
         no_idle = (pick(0, 3) == 0);
         load_ascending(phase == 0 ? TABLE_DEPTH : live_entries);
         repeat (pick(20, 60)) begin
            r = pick(0, 99);
            if (r < 8) send_beat(MODE_LOAD, pick(0, TABLE_DEPTH - 1), rand_word(),
                                 rand_word(), rand_word());
            else if (r < 10) settle(0);
            else send_query();
         end
         phase++;
      end

      settle(SETTLE_CYCLES);
      if (mismatch_count == 0 && answers_outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
rtl/core/tli_pkg.sv
rtl/core/tli_ram.sv
rtl/core/table_linear_interpolator.sv
verif/tli_checker.sv
verif/tb_table_linear_interpolator.sv
